// File: rtl/core/tftcw_pkg.sv
// Shared types, codes and helper functions for the TFT command window pixel writer.
package tftcw_pkg;

  // Event codes carried in the input tuser field.
  localparam logic [1:0] CMD_BYTE       = 2'd0;
  localparam logic [1:0] CMD_HW_RESET   = 2'd1;
  localparam logic [1:0] CMD_CS_RELEASE = 2'd2;

  // Controller opcodes.
  localparam logic [7:0] OP_SWRESET = 8'h01;
  localparam logic [7:0] OP_CASET   = 8'h2A;
  localparam logic [7:0] OP_PASET   = 8'h2B;
  localparam logic [7:0] OP_RAMWR   = 8'h2C;
  localparam logic [7:0] OP_MADCTL  = 8'h36;
  localparam logic [7:0] OP_COLMOD  = 8'h3A;

  // Configuration register indexes.
  localparam logic [1:0] REG_PANEL_WIDTH   = 2'd0;
  localparam logic [1:0] REG_PANEL_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_COLUMN_OFFSET = 2'd2;
  localparam logic [1:0] REG_ROW_OFFSET    = 2'd3;

  localparam int CFG_W       = 9;
  localparam int IDX_W       = 17;
  localparam int COLOR_W     = 32;
  localparam int OUT_TDATA_W = 56;

  localparam logic [CFG_W-1:0] PANEL_WIDTH_RST   = 9'd240;
  localparam logic [CFG_W-1:0] PANEL_HEIGHT_RST  = 9'd135;
  localparam logic [CFG_W-1:0] COLUMN_OFFSET_RST = 9'd40;
  localparam logic [CFG_W-1:0] ROW_OFFSET_RST    = 9'd52;

  // Window start values at or above this limit are taken without offset.
  localparam logic [15:0] OFFSET_LIMIT = 16'd320;

  // x*255/31 and x*255/63 done as one multiply by a scaled reciprocal.
  localparam logic [26:0] R5_MULT = 27'd2156535;  // 255 * ceil(2^18 / 31)
  localparam logic [27:0] G6_MULT = 28'd4244475;  // 255 * ceil(2^20 / 63)
  localparam logic [7:0]  ALPHA   = 8'hFF;

  typedef struct packed {
    logic [CFG_W-1:0] col;
    logic [CFG_W-1:0] row;
    logic [15:0]      raw;
  } pix_req_t;

  function automatic logic [2:0] arg_count(input logic [7:0] op);
    logic [2:0] n;
    n = 3'd0;
    if (op == OP_MADCTL || op == OP_COLMOD) n = 3'd1;
    if (op == OP_CASET || op == OP_PASET) n = 3'd4;
    return n;
  endfunction

  // RGB565 to RGBA8888 with exact rounding down of the channel scaling.
  function automatic logic [COLOR_W-1:0] widen_565(input logic [15:0] raw);
    logic [26:0] r_p;
    logic [27:0] g_p;
    logic [26:0] b_p;
    r_p = 27'(raw[15:11]) * R5_MULT;
    g_p = 28'(raw[10:5]) * G6_MULT;
    b_p = 27'(raw[4:0]) * R5_MULT;
    return {ALPHA, b_p[25:18], g_p[27:20], r_p[25:18]};
  endfunction

endpackage

// File: rtl/core/tftcw_pixel_out.sv
// Pixel result stage: linear index, color widening and the output word register.
module tftcw_pixel_out
  import tftcw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  pix_req_t               pix,
  input  logic [CFG_W-1:0]       panel_width,
  output logic                   can_load,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // pixel_index[16:0], pixel_color[48:17], zeros
);

  logic                   valid_r;
  logic [OUT_TDATA_W-1:0] data_r;
  logic [17:0]            row_mul;
  logic [18:0]            index_sum;
  logic [OUT_TDATA_W-1:0] data_nxt;

  assign row_mul   = 18'(pix.row) * 18'(panel_width);
  assign index_sum = 19'(row_mul) + 19'(pix.col);
  assign data_nxt  = {7'd0, widen_565(pix.raw), index_sum[IDX_W-1:0]};

  assign can_load   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: rtl/core/tft_command_window_pixel_writer_top.sv
// Top level of the TFT command window pixel writer.
// Each input word is one event: a serial byte flagged command or data, a hardware
// reset pulse or a chip-select release. One word is taken every clock cycle unless
// the input stalls; a word sits in the input register while the command decode,
// window set and cursor update run, and any pixel it completes is loaded into the
// output register as the word leaves. The output register lets the next word be
// taken while a pixel still waits; the input stalls only when both registers are
// full and out_tready is low. The user must write configuration registers through
// cfg_we/cfg_addr/cfg_wdata while no word is in flight; the block does not check.
module tft_command_window_pixel_writer_top
  import tftcw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // data_byte[7:0]
  input  logic [2:0]             in_tuser,   // cmd[1:0], dc_flag[2]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // pixel_index[16:0], pixel_color[48:17]
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  logic [CFG_W-1:0] panel_width_r, panel_height_r, column_offset_r, row_offset_r;

  logic       in_valid_r;
  logic [1:0] in_cmd_r;
  logic       in_dc_r;
  logic [7:0] in_byte_r;

  logic        ram_write_r,  ram_write_nxt;
  logic [7:0]  opcode_r,     opcode_nxt;
  logic [2:0]  args_exp_r,   args_exp_nxt;
  logic [2:0]  args_rcv_r,   args_rcv_nxt;
  logic [7:0]  arg_r [4];
  logic [7:0]  arg_nxt [4];
  logic [15:0] col_first_r,  col_first_nxt;
  logic [15:0] col_last_r,   col_last_nxt;
  logic [15:0] row_first_r,  row_first_nxt;
  logic [15:0] row_last_r,   row_last_nxt;
  logic [16:0] cur_col_r,    cur_col_nxt;
  logic [16:0] cur_row_r,    cur_row_nxt;
  logic        half_pend_r,  half_pend_nxt;
  logic [7:0]  half_byte_r,  half_byte_nxt;

  logic        proceed;
  logic        can_load;
  logic        pix_load;
  pix_req_t    pix;
  logic [2:0]  cmd_args;
  logic [15:0] win_start, win_end, win_off;
  logic [15:0] win_start_adj, win_end_adj;
  logic        win_in_range;
  logic [16:0] col_inc, row_inc;
  logic        pix_inside;

  assign proceed   = in_valid_r && can_load;
  assign in_tready = !in_valid_r || can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_cmd_r  <= in_tuser[1:0];
      in_dc_r   <= in_tuser[2];
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_width_r   <= PANEL_WIDTH_RST;
      panel_height_r  <= PANEL_HEIGHT_RST;
      column_offset_r <= COLUMN_OFFSET_RST;
      row_offset_r    <= ROW_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PANEL_WIDTH:   panel_width_r   <= cfg_wdata;
        REG_PANEL_HEIGHT:  panel_height_r  <= cfg_wdata;
        REG_COLUMN_OFFSET: column_offset_r <= cfg_wdata;
        REG_ROW_OFFSET:    row_offset_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Window arguments: the final byte of a window set is always the fourth.
  assign cmd_args      = arg_count(in_byte_r);
  assign win_start     = {arg_r[0], arg_r[1]};
  assign win_end       = {arg_r[2], in_byte_r};
  assign win_off       = (opcode_r == OP_PASET) ? 16'(row_offset_r) : 16'(column_offset_r);
  assign win_in_range  = (win_start >= win_off) && (win_start < OFFSET_LIMIT);
  assign win_start_adj = win_in_range ? win_start - win_off : win_start;
  assign win_end_adj   = win_in_range ? win_end - win_off : win_end;

  assign col_inc    = cur_col_r + 17'd1;
  assign row_inc    = cur_row_r + 17'd1;
  assign pix_inside = (cur_col_r < 17'(panel_width_r)) && (cur_row_r < 17'(panel_height_r));

  assign pix.col = cur_col_r[CFG_W-1:0];
  assign pix.row = cur_row_r[CFG_W-1:0];
  assign pix.raw = {half_byte_r, in_byte_r};

  always_comb begin
    ram_write_nxt = ram_write_r;
    opcode_nxt    = opcode_r;
    args_exp_nxt  = args_exp_r;
    args_rcv_nxt  = args_rcv_r;
    arg_nxt       = arg_r;
    col_first_nxt = col_first_r;
    col_last_nxt  = col_last_r;
    row_first_nxt = row_first_r;
    row_last_nxt  = row_last_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    half_pend_nxt = half_pend_r;
    half_byte_nxt = half_byte_r;
    pix_load      = 1'b0;

    if (proceed) begin
      case (in_cmd_r)
        CMD_HW_RESET: begin
          ram_write_nxt = 1'b0;
          cur_col_nxt   = '0;
          cur_row_nxt   = '0;
          col_first_nxt = '0;
          col_last_nxt  = 16'(panel_width_r) - 16'd1;
          row_first_nxt = '0;
          row_last_nxt  = 16'(panel_height_r) - 16'd1;
          args_exp_nxt  = '0;
          args_rcv_nxt  = '0;
          half_pend_nxt = 1'b0;
        end
        CMD_CS_RELEASE: begin
          half_pend_nxt = 1'b0;
        end
        CMD_BYTE: begin
          if (!in_dc_r) begin
            ram_write_nxt = 1'b0;
            half_pend_nxt = 1'b0;
            opcode_nxt    = in_byte_r;
            args_exp_nxt  = cmd_args;
            args_rcv_nxt  = '0;
            // Opcodes without arguments take effect at once.
            if (cmd_args == 3'd0) begin
              if (in_byte_r == OP_SWRESET) begin
                cur_col_nxt   = '0;
                cur_row_nxt   = '0;
                col_first_nxt = '0;
                col_last_nxt  = 16'(panel_width_r) - 16'd1;
                row_first_nxt = '0;
                row_last_nxt  = 16'(panel_height_r) - 16'd1;
              end else if (in_byte_r == OP_RAMWR) begin
                ram_write_nxt = 1'b1;
                cur_col_nxt   = 17'(col_first_r);
                cur_row_nxt   = 17'(row_first_r);
              end
            end
          end else if (!ram_write_r) begin
            if (args_rcv_r < args_exp_r) begin
              arg_nxt[args_rcv_r[1:0]] = in_byte_r;
              args_rcv_nxt             = args_rcv_r + 3'd1;
              if (args_rcv_nxt == args_exp_r) begin
                if (opcode_r == OP_CASET) begin
                  col_first_nxt = win_start_adj;
                  col_last_nxt  = win_end_adj;
                  cur_col_nxt   = 17'(win_start_adj);
                end else if (opcode_r == OP_PASET) begin
                  row_first_nxt = win_start_adj;
                  row_last_nxt  = win_end_adj;
                  cur_row_nxt   = 17'(win_start_adj);
                end
              end
            end
          end else if (!half_pend_r) begin
            half_pend_nxt = 1'b1;
            half_byte_nxt = in_byte_r;
          end else begin
            half_pend_nxt = 1'b0;
            pix_load      = pix_inside;
            // Column wraps inside the window, then the row does the same.
            if (col_inc > 17'(col_last_r)) begin
              cur_col_nxt = 17'(col_first_r);
              if (row_inc > 17'(row_last_r)) begin
                cur_row_nxt = 17'(row_first_r);
              end else begin
                cur_row_nxt = row_inc;
              end
            end else begin
              cur_col_nxt = col_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_write_r <= 1'b0;
      opcode_r    <= '0;
      args_exp_r  <= '0;
      args_rcv_r  <= '0;
      col_first_r <= '0;
      col_last_r  <= 16'(PANEL_WIDTH_RST) - 16'd1;
      row_first_r <= '0;
      row_last_r  <= 16'(PANEL_HEIGHT_RST) - 16'd1;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      half_pend_r <= 1'b0;
    end else begin
      ram_write_r <= ram_write_nxt;
      opcode_r    <= opcode_nxt;
      args_exp_r  <= args_exp_nxt;
      args_rcv_r  <= args_rcv_nxt;
      col_first_r <= col_first_nxt;
      col_last_r  <= col_last_nxt;
      row_first_r <= row_first_nxt;
      row_last_r  <= row_last_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      half_pend_r <= half_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    arg_r       <= arg_nxt;
    half_byte_r <= half_byte_nxt;
  end

  tftcw_pixel_out u_pixel_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (pix_load),
    .pix         (pix),
    .panel_width (panel_width_r),
    .can_load    (can_load),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule
